FILE: hdl/gga_position_field_extractor_macros.svh
// assertion macros shared by the gga position field extractor rtl
`ifndef GGA_POSITION_FIELD_EXTRACTOR_MACROS_SVH
`define GGA_POSITION_FIELD_EXTRACTOR_MACROS_SVH

// condition holds at every edge out of reset
`define GPFE_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define GPFE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/gpfe_pkg.sv
// constants, control word type and microprogram of the gga position field extractor
package gpfe_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int CHAR_W    = 8;
	localparam int STEP_W    = 4;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [0:0]        cfg_idx_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam cfg_idx_t REG_LAT_END = 1'd0;
	localparam cfg_idx_t REG_LON_END = 1'd1;

	localparam char_t LAT_END_RST = 8'h4E;
	localparam char_t LON_END_RST = 8'h45;

	localparam char_t CH_DOLLAR = 8'h24;
	localparam char_t CH_G      = 8'h47;
	localparam char_t CH_P      = 8'h50;
	localparam char_t CH_A      = 8'h41;
	localparam char_t CH_COMMA  = 8'h2C;

	localparam step_t STEP_HUNT     = 4'd0;
	localparam step_t STEP_G1       = 4'd1;
	localparam step_t STEP_P        = 4'd2;
	localparam step_t STEP_G2       = 4'd3;
	localparam step_t STEP_G3       = 4'd4;
	localparam step_t STEP_A        = 4'd5;
	localparam step_t STEP_COMMA    = 4'd6;
	localparam step_t STEP_TIME     = 4'd7;
	localparam step_t STEP_LAT      = 4'd8;
	localparam step_t STEP_LATCOMMA = 4'd9;
	localparam step_t STEP_LON      = 4'd10;
	localparam step_t STEP_EMIT_LAT = 4'd11;
	localparam step_t STEP_EMIT_LON = 4'd12;

	typedef logic [1:0] cmp_sel_t;
	localparam cmp_sel_t CMP_CONST = 2'd0;
	localparam cmp_sel_t CMP_LAT   = 2'd1;
	localparam cmp_sel_t CMP_LON   = 2'd2;

	typedef logic [2:0] op_t;
	localparam op_t OP_NONE      = 3'd0;
	localparam op_t OP_CLR_LAT   = 3'd1;
	localparam op_t OP_CLR_LON   = 3'd2;
	localparam op_t OP_STORE_LAT = 3'd3;
	localparam op_t OP_STORE_LON = 3'd4;
	localparam op_t OP_EMIT_LAT  = 3'd5;
	localparam op_t OP_EMIT_LON  = 3'd6;

	typedef struct packed {
		logic     wait_byte;
		cmp_sel_t cmp_sel;
		char_t    cmp_char;
		op_t      op;
		step_t    jump_hit;
		step_t    jump_miss;
	} ctl_t;

	function automatic ctl_t mk_ctl(logic wait_byte, cmp_sel_t sel, char_t ch, op_t op,
			step_t hit, step_t miss);
		ctl_t c;
		c.wait_byte = wait_byte;
		c.cmp_sel   = sel;
		c.cmp_char  = ch;
		c.op        = op;
		c.jump_hit  = hit;
		c.jump_miss = miss;
		return c;
	endfunction

	// microprogram; for emit steps a hit means the last entry of that store
	function automatic ctl_t prog_rom(step_t step);
		ctl_t c;
		case (step)
			STEP_G1:       c = mk_ctl(1'b1, CMP_CONST, CH_G, OP_NONE, STEP_P, STEP_HUNT);
			STEP_P:        c = mk_ctl(1'b1, CMP_CONST, CH_P, OP_NONE, STEP_G2, STEP_HUNT);
			STEP_G2:       c = mk_ctl(1'b1, CMP_CONST, CH_G, OP_NONE, STEP_G3, STEP_HUNT);
			STEP_G3:       c = mk_ctl(1'b1, CMP_CONST, CH_G, OP_NONE, STEP_A, STEP_HUNT);
			STEP_A:        c = mk_ctl(1'b1, CMP_CONST, CH_A, OP_NONE, STEP_COMMA, STEP_HUNT);
			STEP_COMMA:    c = mk_ctl(1'b1, CMP_CONST, CH_COMMA, OP_NONE, STEP_TIME,
				STEP_HUNT);
			STEP_TIME:     c = mk_ctl(1'b1, CMP_CONST, CH_COMMA, OP_CLR_LAT, STEP_LAT,
				STEP_TIME);
			STEP_LAT:      c = mk_ctl(1'b1, CMP_LAT, CH_COMMA, OP_STORE_LAT, STEP_LATCOMMA,
				STEP_LAT);
			STEP_LATCOMMA: c = mk_ctl(1'b1, CMP_CONST, CH_COMMA, OP_CLR_LON, STEP_LON,
				STEP_HUNT);
			STEP_LON:      c = mk_ctl(1'b1, CMP_LON, CH_COMMA, OP_STORE_LON, STEP_EMIT_LAT,
				STEP_LON);
			STEP_EMIT_LAT: c = mk_ctl(1'b0, CMP_CONST, CH_COMMA, OP_EMIT_LAT, STEP_EMIT_LON,
				STEP_EMIT_LAT);
			STEP_EMIT_LON: c = mk_ctl(1'b0, CMP_CONST, CH_COMMA, OP_EMIT_LON, STEP_HUNT,
				STEP_EMIT_LON);
			default:       c = mk_ctl(1'b1, CMP_CONST, CH_DOLLAR, OP_NONE, STEP_G1,
				STEP_HUNT);
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/gpfe_if.sv
// valid/ready channel interfaces for received bytes and emitted position characters
interface gpfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface gpfe_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       field_tag;
	logic       run_last;

	modport source (output valid, output out_char, output field_tag, output run_last,
		input ready);
	modport sink (input valid, input out_char, input field_tag, input run_last,
		output ready);
endinterface

FILE: hdl/gga_position_field_extractor.sv
// gga position field extractor: microcoded parser of nmea gga latitude and longitude
//
//  channel | dir | payload                          | request taken when
//  rx      | in  | rx_byte[7:0]                     | rx.valid && rx.ready
//  tx      | out | out_char[7:0] field_tag run_last | tx.valid && tx.ready
//  cfg     | in  | cfg_index, cfg_wdata[7:0]        | cfg_we
//
// one byte per cycle while parsing; each byte runs one step of the microprogram
// on the longitude terminator the emit steps send lat_count + lon_count characters,
// one per cycle through the single output register, and take no byte meanwhile
// a stall on tx holds the emit step; the next byte is taken while the last one waits
// reset returns to hunting for the dollar sign; the character stores need no clearing
`include "gga_position_field_extractor_macros.svh"

module gga_position_field_extractor (
	input  logic                clk,
	input  logic                arst_n,
	gpfe_byte_if.sink           rx,
	gpfe_char_if.source         tx,
	input  logic                cfg_we,
	input  gpfe_pkg::cfg_idx_t  cfg_index,
	input  gpfe_pkg::char_t     cfg_wdata
);
	import gpfe_pkg::*;

	step_t            step_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] lat_cnt_q;
	logic [CNT_W-1:0] lon_cnt_q;
	char_t            lat_end_q;
	char_t            lon_end_q;
	char_t            lat_mem_q [BUF_DEPTH];
	char_t            lon_mem_q [BUF_DEPTH];

	logic             tx_valid_q;
	char_t            tx_char_q;
	logic             tx_tag_q;
	logic             tx_last_q;

	ctl_t             ctl;
	char_t            cmp_val;
	logic             take;
	logic             out_free;
	logic             emit_go;
	logic             emit_step;
	logic             emit_hit;
	logic             store_lat;
	logic             store_lon;
	logic             full;
	logic             hit;
	char_t            emit_char;

	assign ctl      = prog_rom(step_q);
	assign rx.ready = ctl.wait_byte;
	assign take     = rx.valid && ctl.wait_byte;
	assign out_free = !tx_valid_q || tx.ready;

	assign emit_step = (ctl.op == OP_EMIT_LAT) || (ctl.op == OP_EMIT_LON);
	assign emit_go   = emit_step && out_free;
	assign store_lat = ctl.op == OP_STORE_LAT;
	assign store_lon = ctl.op == OP_STORE_LON;

	always_comb begin
		case (ctl.cmp_sel)
			CMP_LAT: cmp_val = lat_end_q;
			CMP_LON: cmp_val = lon_end_q;
			default: cmp_val = ctl.cmp_char;
		endcase
	end

	assign hit  = rx.rx_byte == cmp_val;
	assign full = (store_lat && (lat_cnt_q == CNT_W'(BUF_DEPTH)))
		|| (store_lon && (lon_cnt_q == CNT_W'(BUF_DEPTH)));

	// last stored entry of the field being emitted
	always_comb begin
		if (ctl.op == OP_EMIT_LON) begin
			emit_hit  = (CNT_W'(idx_q) + CNT_W'(1)) == lon_cnt_q;
			emit_char = lon_mem_q[idx_q];
		end else begin
			emit_hit  = (CNT_W'(idx_q) + CNT_W'(1)) == lat_cnt_q;
			emit_char = lat_mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_HUNT;
			idx_q     <= '0;
			lat_cnt_q <= '0;
			lon_cnt_q <= '0;
			lat_end_q <= LAT_END_RST;
			lon_end_q <= LON_END_RST;
			tx_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LAT_END: lat_end_q <= cfg_wdata;
					REG_LON_END: lon_end_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (take) begin
				if (full) begin
					step_q <= STEP_HUNT;
				end else begin
					step_q <= hit ? ctl.jump_hit : ctl.jump_miss;
					if (store_lat) lat_cnt_q <= lat_cnt_q + CNT_W'(1);
					if (store_lon) lon_cnt_q <= lon_cnt_q + CNT_W'(1);
					if (hit && ctl.op == OP_CLR_LAT) lat_cnt_q <= '0;
					if (hit && ctl.op == OP_CLR_LON) lon_cnt_q <= '0;
				end
			end else if (emit_go) begin
				step_q <= emit_hit ? ctl.jump_hit : ctl.jump_miss;
				idx_q  <= emit_hit ? '0 : idx_q + IDX_W'(1);
			end

			if (emit_go) begin
				tx_valid_q <= 1'b1;
			end else if (tx.ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	// character stores and output payload, no reset
	always_ff @(posedge clk) begin
		if (take && store_lat && !full) lat_mem_q[lat_cnt_q[IDX_W-1:0]] <= rx.rx_byte;
		if (take && store_lon && !full) lon_mem_q[lon_cnt_q[IDX_W-1:0]] <= rx.rx_byte;
		if (emit_go) begin
			tx_char_q <= emit_char;
			tx_tag_q  <= ctl.op == OP_EMIT_LON;
			tx_last_q <= (ctl.op == OP_EMIT_LON) && emit_hit;
		end
	end

	assign tx.valid     = tx_valid_q;
	assign tx.out_char  = tx_char_q;
	assign tx.field_tag = tx_tag_q;
	assign tx.run_last  = tx_last_q;

	`GPFE_ASSERT_HOLDS(a_lat_cnt_range, lat_cnt_q <= CNT_W'(BUF_DEPTH), "lat count overrun")
	`GPFE_ASSERT_HOLDS(a_lon_cnt_range, lon_cnt_q <= CNT_W'(BUF_DEPTH), "lon count overrun")
	`GPFE_ASSERT_IMPLIES(a_no_rx_in_emit, rx.ready, !emit_step, "byte taken during emit")
	`GPFE_ASSERT_IMPLIES(a_last_is_lon, tx.valid && tx.run_last, tx.field_tag, "last on lat")
	`GPFE_ASSERT_NEXT(a_emit_done_hunt, (ctl.op == OP_EMIT_LON) && out_free && emit_hit,
		step_q == STEP_HUNT, "emit end did not return to hunt")

endmodule
